// ----- rtl/cdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the countdown timer
// Holds the command and phase codes, the timer state word, the time
// constants and the step-size lookup used by the datapath and the top level.
// ----------------------------------------------------------------------------
package cdt_pkg;

	localparam int TIME_W = 64;
	localparam int SEC_W  = 13;
	localparam int MS_W   = 23;
	localparam int US_W   = 33;
	localparam int STEP_W = 6;
	localparam int DET_W  = 7;
	localparam int CODE_W = 2;

	// Command codes carried by each input word.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_TOGGLE = 2'd2,
		CMD_RESET  = 2'd3
	} cmd_t;

	// Timer phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_RUNNING  = 4'b0010,
		PH_PAUSED   = 4'b0100,
		PH_COMPLETE = 4'b1000
	} phase_t;

	// Encoded phase as reported on the result word.
	localparam logic [CODE_W-1:0] CODE_IDLE     = 2'd0;
	localparam logic [CODE_W-1:0] CODE_RUNNING  = 2'd1;
	localparam logic [CODE_W-1:0] CODE_PAUSED   = 2'd2;
	localparam logic [CODE_W-1:0] CODE_COMPLETE = 2'd3;

	localparam logic [SEC_W-1:0] MIN_SEC     = 13'd5;
	localparam logic [SEC_W-1:0] MAX_SEC     = 13'd5400;
	localparam logic [SEC_W-1:0] DEFAULT_SEC = 13'd300;

	localparam logic [SEC_W-1:0] STEP_LIM_A = 13'd60;
	localparam logic [SEC_W-1:0] STEP_LIM_B = 13'd300;
	localparam logic [SEC_W-1:0] STEP_LIM_C = 13'd1200;

	localparam logic [STEP_W-1:0] STEP_5  = 6'd5;
	localparam logic [STEP_W-1:0] STEP_15 = 6'd15;
	localparam logic [STEP_W-1:0] STEP_30 = 6'd30;
	localparam logic [STEP_W-1:0] STEP_60 = 6'd60;

	localparam logic [MS_W-1:0] MS_PER_SEC = 23'd1000;
	localparam logic [US_W-1:0] US_PER_SEC = 33'd1000000;
	localparam logic [US_W-1:0] US_PER_MS  = 33'd1000;

	localparam logic [MS_W-1:0] DEFAULT_MS = 23'd300000;
	localparam logic [US_W-1:0] DEFAULT_US = 33'd300000000;

	// floor(x / 125) = (x * DIV125_RECIP) >> DIV125_SHIFT, exact for x below 2^30.
	localparam int              RECIP_W      = 31;
	localparam int              DIV125_SHIFT = 37;
	localparam logic [RECIP_W-1:0] DIV125_RECIP = 31'd1099511628;

	typedef struct packed {
		phase_t              phase;
		logic [SEC_W-1:0]    dur_sec;
		logic [MS_W-1:0]     dur_ms;
		logic [US_W-1:0]     dur_us;
		logic [MS_W-1:0]     rem_ms;
		logic [TIME_W-1:0]   start_us;
	} timer_state_t;

	localparam timer_state_t STATE_RESET = '{
		phase:    PH_IDLE,
		dur_sec:  DEFAULT_SEC,
		dur_ms:   DEFAULT_MS,
		dur_us:   DEFAULT_US,
		rem_ms:   DEFAULT_MS,
		start_us: '0
	};

	// Adjust step in seconds for a given duration in seconds.
	function automatic logic [STEP_W-1:0] step_for(input logic [SEC_W-1:0] secs);
		logic [STEP_W-1:0] s;
		priority if (secs < STEP_LIM_A) begin
			s = STEP_5;
		end else if (secs < STEP_LIM_B) begin
			s = STEP_15;
		end else if (secs < STEP_LIM_C) begin
			s = STEP_30;
		end else begin
			s = STEP_60;
		end
		return s;
	endfunction

	function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
		logic [CODE_W-1:0] c;
		unique case (ph)
			PH_IDLE:     c = CODE_IDLE;
			PH_RUNNING:  c = CODE_RUNNING;
			PH_PAUSED:   c = CODE_PAUSED;
			PH_COMPLETE: c = CODE_COMPLETE;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cdt_next.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_next: next-state logic of the countdown timer
// Applies one command to the current timer state and gives the new state.
// ----------------------------------------------------------------------------
module cdt_next
	import cdt_pkg::*;
(
	input  timer_state_t                cur,
	input  cmd_t                        command,
	input  logic [TIME_W-1:0]           now_us,
	input  logic signed [DET_W-1:0]     detents,
	output timer_state_t                nxt
);

	localparam int SUM_W  = 15;
	localparam int PROD_W = 30 + RECIP_W;

	// Tick: elapsed milliseconds since the start time.
	logic                  after_start;
	logic [TIME_W-1:0]     diff_us;
	logic                  reached;
	logic [29:0]           diff_div8;
	logic [PROD_W-1:0]     div_prod;
	logic [MS_W-1:0]       passed_ms;
	logic [MS_W-1:0]       tick_rem;

	assign after_start = now_us > cur.start_us;
	assign diff_us     = now_us - cur.start_us;
	assign reached     = after_start && (diff_us >= {{(TIME_W-US_W){1'b0}}, cur.dur_us});
	// Below the duration the difference fits in 33 bits: divide by 8, then by 125.
	assign diff_div8   = diff_us[US_W-1:3];
	assign div_prod    = {{(PROD_W-30){1'b0}}, diff_div8}
	                   * {{(PROD_W-RECIP_W){1'b0}}, DIV125_RECIP};
	assign passed_ms   = after_start ? div_prod[DIV125_SHIFT +: MS_W] : '0;
	assign tick_rem    = cur.dur_ms - passed_ms;

	// Adjust: new duration in whole seconds, clamped.
	logic [STEP_W-1:0]        step;
	logic signed [SUM_W-1:0]  det_x;
	logic signed [SUM_W-1:0]  step_x;
	logic signed [SUM_W-1:0]  delta;
	logic signed [SUM_W-1:0]  secs;
	logic [SEC_W-1:0]         new_sec;
	logic [MS_W-1:0]          new_ms;
	logic [US_W-1:0]          new_us;

	assign step   = step_for(cur.dur_sec);
	assign det_x  = {{(SUM_W-DET_W){detents[DET_W-1]}}, detents};
	assign step_x = {{(SUM_W-STEP_W){1'b0}}, step};
	assign delta  = det_x * step_x;
	assign secs   = $signed({{(SUM_W-SEC_W){1'b0}}, cur.dur_sec}) + delta;

	always_comb begin
		priority if (secs < $signed({{(SUM_W-SEC_W){1'b0}}, MIN_SEC})) begin
			new_sec = MIN_SEC;
		end else if (secs > $signed({{(SUM_W-SEC_W){1'b0}}, MAX_SEC})) begin
			new_sec = MAX_SEC;
		end else begin
			new_sec = secs[SEC_W-1:0];
		end
	end

	assign new_ms = {{(MS_W-SEC_W){1'b0}}, new_sec} * MS_PER_SEC;
	assign new_us = {{(US_W-SEC_W){1'b0}}, new_sec} * US_PER_SEC;

	// Resume: shift the start time back by the time already used.
	logic [MS_W-1:0]   used_ms;
	logic [US_W-1:0]   used_us;

	assign used_ms = cur.dur_ms - cur.rem_ms;
	assign used_us = {{(US_W-MS_W){1'b0}}, used_ms} * US_PER_MS;

	always_comb begin
		nxt = cur;
		unique case (command)
			CMD_TICK: begin
				if (cur.phase == PH_RUNNING) begin
					if (reached) begin
						nxt.rem_ms = '0;
						nxt.phase  = PH_COMPLETE;
					end else begin
						nxt.rem_ms = tick_rem;
					end
				end
			end
			CMD_ADJUST: begin
				if ((detents != '0) && (cur.phase != PH_RUNNING)) begin
					nxt.dur_sec  = new_sec;
					nxt.dur_ms   = new_ms;
					nxt.dur_us   = new_us;
					nxt.rem_ms   = new_ms;
					nxt.start_us = '0;
					nxt.phase    = PH_IDLE;
				end
			end
			CMD_TOGGLE: begin
				unique case (cur.phase)
					PH_RUNNING: begin
						nxt.rem_ms = reached ? '0 : tick_rem;
						nxt.phase  = PH_PAUSED;
					end
					PH_PAUSED: begin
						nxt.start_us = now_us - {{(TIME_W-US_W){1'b0}}, used_us};
						nxt.phase    = PH_RUNNING;
					end
					PH_COMPLETE: begin
						nxt.rem_ms   = cur.dur_ms;
						nxt.start_us = now_us;
						nxt.phase    = PH_RUNNING;
					end
					PH_IDLE: begin
						nxt.start_us = now_us;
						nxt.phase    = PH_RUNNING;
					end
					default: begin
						nxt.phase = PH_IDLE;
					end
				endcase
			end
			CMD_RESET: begin
				nxt.rem_ms   = cur.dur_ms;
				nxt.start_us = '0;
				nxt.phase    = PH_IDLE;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/countdown_timer_with_step_adjust_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// countdown_timer_with_step_adjust_unit: countdown timer command processor
// Stage 1 registers each accepted word and stage 2 its result word.
// Throughput: one word per cycle while the output takes its words; the timer
// state is updated as each word leaves stage 1, from the last word's state.
// Reset: arst_n clears the pipeline and returns the timer to idle with a
// 300 s duration, full remaining time and a zero start time.
// ----------------------------------------------------------------------------
module countdown_timer_with_step_adjust_unit
	import cdt_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [TIME_W-1:0]          now_us,
	input  logic signed [DET_W-1:0]    detents,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [CODE_W-1:0]          run_state,
	output logic [MS_W-1:0]            total_ms,
	output logic [MS_W-1:0]            left_ms,
	output logic [STEP_W-1:0]          adj_step
);

	// Stage 1 holds the accepted command word. When it moves on, the timer
	// state is updated and a snapshot of the new state is captured in the
	// stage 2 result register, which drives the output word.
	logic                      valid_s1;
	cmd_t                      cmd_s1;
	logic [TIME_W-1:0]         now_s1;
	logic signed [DET_W-1:0]   det_s1;

	logic                      valid_s2;
	logic [CODE_W-1:0]         state_s2;
	logic [MS_W-1:0]           dur_s2;
	logic [MS_W-1:0]           rem_s2;
	logic [STEP_W-1:0]         step_s2;

	timer_state_t              timer_q;
	timer_state_t              timer_nxt;

	logic                      adv_s1;

	// Stage 1 moves forward whenever the result register is empty or is
	// being drained this cycle; that keeps one word per cycle flowing as
	// long as the output side takes its words. A result held at the output
	// by out_stall freezes stage 1 and with it stalls the input.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd_t'(command);
			now_s1 <= now_us;
			det_s1 <= detents;
		end
	end

	cdt_next u_next (
		.cur     (timer_q),
		.command (cmd_s1),
		.now_us  (now_s1),
		.detents (det_s1),
		.nxt     (timer_nxt)
	);

	// Timer state: phase, duration (seconds, ms and us forms kept side by
	// side so no conversion sits on the tick path), remaining ms, start time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= STATE_RESET;
		end else if (adv_s1) begin
			timer_q <= timer_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			state_s2 <= phase_code(timer_nxt.phase);
			dur_s2   <= timer_nxt.dur_ms;
			rem_s2   <= timer_nxt.rem_ms;
			step_s2  <= step_for(timer_nxt.dur_sec);
		end
	end

	assign out_valid = valid_s2;
	assign run_state = state_s2;
	assign total_ms  = dur_s2;
	assign left_ms   = rem_s2;
	assign adj_step  = step_s2;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the countdown timer command processor
// Sends tick, adjust, toggle and reset words to the timer and predicts the
// snapshot that each one must return. A short directed run covers the clamp
// limits, step boundaries and time-wrap corners. A long random run follows,
// with idle bursts on both handshakes, one long output hold-off and one
// full drain.
// ----------------------------------------------------------------------------
module tb_top;
	import cdt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	localparam int RANDOM_WORDS   = 1900;
	localparam int SETTLE_CYCLES  = 8;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              command;
	logic [TIME_W-1:0]       now_us;
	logic signed [DET_W-1:0] detents;
	logic                    out_valid;
	logic                    out_stall;
	logic [CODE_W-1:0]       run_state;
	logic [MS_W-1:0]         total_ms;
	logic [MS_W-1:0]         left_ms;
	logic [STEP_W-1:0]       adj_step;

	// One snapshot of the timer as the block reports it.
	typedef struct packed {
		logic [CODE_W-1:0] state;
		logic [MS_W-1:0]   dur;
		logic [MS_W-1:0]   rem;
		logic [STEP_W-1:0] step;
	} snapshot_t;

	// Keeps its own copy of the timer, advances it on every accepted input
	// word and holds the snapshots that the block still owes us.
	class timer_scoreboard;
		logic [CODE_W-1:0] phase;
		logic [MS_W-1:0]   dur_ms;
		logic [MS_W-1:0]   rem_ms;
		logic [TIME_W-1:0] start_us;
		snapshot_t         snapshots_due[$];
		int                errors;

		function new();
			errors = 0;
			clear_timer();
		endfunction

		function void clear_timer();
			phase    = CODE_IDLE;
			dur_ms   = DEFAULT_MS;
			rem_ms   = DEFAULT_MS;
			start_us = '0;
		endfunction

		function int pending();
			return snapshots_due.size();
		endfunction

		// Coarser steps for longer durations.
		function logic [STEP_W-1:0] step_size(logic [SEC_W-1:0] secs);
			if (secs < 13'd60) begin
				return 6'd5;
			end else if (secs < 13'd300) begin
				return 6'd15;
			end else if (secs < 13'd1200) begin
				return 6'd30;
			end
			return 6'd60;
		endfunction

		function void run_tick(logic [TIME_W-1:0] t);
			logic [TIME_W-1:0] passed_ms;
			if (phase != CODE_RUNNING) begin
				return;
			end
			// A clock reading at or before the start counts as no time at all.
			passed_ms = (t > start_us) ? (t - start_us) / 64'd1000 : 64'd0;
			if (passed_ms >= {41'd0, dur_ms}) begin
				rem_ms = '0;
				phase  = CODE_COMPLETE;
			end else begin
				rem_ms = dur_ms - passed_ms[MS_W-1:0];
			end
		endfunction

		function void run_adjust(logic signed [DET_W-1:0] det);
			int cur_sec;
			int new_sec;
			if (det == 0 || phase == CODE_RUNNING) begin
				return;
			end
			cur_sec = int'(dur_ms / 23'd1000);
			new_sec = cur_sec + int'(det) * int'(step_size(cur_sec[SEC_W-1:0]));
			if (new_sec < 5) begin
				new_sec = 5;
			end
			if (new_sec > 5400) begin
				new_sec = 5400;
			end
			dur_ms   = MS_W'(new_sec * 1000);
			rem_ms   = dur_ms;
			start_us = '0;
			phase    = CODE_IDLE;
		endfunction

		function void run_toggle(logic [TIME_W-1:0] t);
			logic [MS_W-1:0] used_ms;
			case (phase)
				CODE_RUNNING: begin
					run_tick(t);
					phase = CODE_PAUSED;
				end
				CODE_PAUSED: begin
					// Shift the start back by the time already spent; may wrap.
					used_ms  = dur_ms - rem_ms;
					start_us = t - {41'd0, used_ms} * 64'd1000;
					phase    = CODE_RUNNING;
				end
				default: begin
					if (phase == CODE_COMPLETE) begin
						rem_ms = dur_ms;
					end
					start_us = t;
					phase    = CODE_RUNNING;
				end
			endcase
		endfunction

		function void note_input(cmd_t c, logic [TIME_W-1:0] t, logic signed [DET_W-1:0] det);
			snapshot_t snap;
			case (c)
				CMD_TICK:   run_tick(t);
				CMD_ADJUST: run_adjust(det);
				CMD_TOGGLE: run_toggle(t);
				default: begin
					rem_ms   = dur_ms;
					phase    = CODE_IDLE;
					start_us = '0;
				end
			endcase
			snap.state = phase;
			snap.dur   = dur_ms;
			snap.rem   = rem_ms;
			snap.step  = step_size(SEC_W'(dur_ms / 23'd1000));
			snapshots_due.push_back(snap);
		endfunction

		function void check_result(logic [CODE_W-1:0] rs, logic [MS_W-1:0] dur,
				logic [MS_W-1:0] rem, logic [STEP_W-1:0] step);
			snapshot_t want;
			if (snapshots_due.size() == 0) begin
				$error("result word with nothing expected: run_state %0d total_ms %0d",
					rs, dur);
				errors++;
				return;
			end
			want = snapshots_due.pop_front();
			if (rs !== want.state) begin
				$error("run_state: expected %0d, got %0d", want.state, rs);
				errors++;
			end
			if (dur !== want.dur) begin
				$error("total_ms: expected %0d, got %0d", want.dur, dur);
				errors++;
			end
			if (rem !== want.rem) begin
				$error("left_ms: expected %0d, got %0d", want.rem, rem);
				errors++;
			end
			if (step !== want.step) begin
				$error("adj_step: expected %0d, got %0d", want.step, step);
				errors++;
			end
		endfunction
	endclass

	timer_scoreboard sb = new();

	// Idle controls shared by the sender and the receiver. The percentages
	// set how often an idle burst starts on the sending and receiving sides.
	int tx_gap_pct;
	int rx_gap_pct;
	bit hold_req;

	// Virtual wall clock for well-formed sequences, in microseconds.
	logic [TIME_W-1:0] wall_us;

	countdown_timer_with_step_adjust_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.now_us       (now_us),
		.detents      (detents),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.run_state    (run_state),
		.total_ms     (total_ms),
		.left_ms      (left_ms),
		.adj_step     (adj_step)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one word and hold it until the block takes it. Every signal is
	// changed at most once per edge, so a word offered right after the
	// previous one keeps valid high without a glitch. The scoreboard learns
	// about the word in the cycle it is accepted.
	task automatic put_word(cmd_t c, logic [TIME_W-1:0] t, logic signed [DET_W-1:0] det);
		command  <= c;
		now_us   <= t;
		detents  <= det;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_input(c, t, det);
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop offering words until every snapshot has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Build one random word. Most words follow a forward-moving wall clock so
	// that runs, pauses and completions happen; a few carry a clock reading
	// taken from anywhere in the 64-bit range.
	task automatic random_word();
		cmd_t                    c;
		logic [TIME_W-1:0]       t;
		logic signed [DET_W-1:0] det;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c = CMD_TICK;
		end else if (pick < 70) begin
			c = CMD_TOGGLE;
		end else if (pick < 90) begin
			c = CMD_ADJUST;
		end else begin
			c = CMD_RESET;
		end
		case ($urandom_range(0, 4))
			0: wall_us += 64'($urandom_range(0, 999));
			1: wall_us += 64'($urandom_range(0, 2_000_000));
			2: wall_us += 64'($urandom_range(0, 20_000_000));
			3: wall_us += 64'($urandom_range(0, 400_000_000));
			default: wall_us += 64'($urandom_range(0, 6_000_000));
		endcase
		if ($urandom_range(0, 99) < 8) begin
			t = {$urandom, $urandom};
		end else begin
			t = wall_us;
		end
		// Small counts drift the duration down so short timers are common;
		// the occasional full-range count hits the clamps from both sides.
		if ($urandom_range(0, 99) < 85) begin
			det = DET_W'($urandom_range(0, 5) - 3);
		end else begin
			det = DET_W'($urandom_range(0, 127));
		end
		put_word(c, t, det);
	endtask

	// Receiver: checks every accepted result word and throttles the output
	// with random stall bursts. A hold request from the stimulus turns into
	// one long stall so the block backs up and stalls its input.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(run_state, total_ms, left_ms, adj_step);
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		logic [TIME_W-1:0] base_us;
		in_valid   = 1'b0;
		command    = CMD_TICK;
		now_us     = '0;
		detents    = '0;
		arst_n     = 1'b0;
		hold_req   = 1'b0;
		tx_gap_pct = 20;
		rx_gap_pct = 20;
		wall_us    = {24'd0, $urandom, 8'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A tick while idle changes nothing, and a zero count
		// is not an adjustment.
		put_word(CMD_TICK,   64'd0, 7'sd0);
		put_word(CMD_ADJUST, 64'd0, 7'sd0);
		// Largest counts: up from 300 s, into the upper clamp, back down and
		// into the lower clamp.
		put_word(CMD_ADJUST, 64'd0, 7'sd63);
		put_word(CMD_ADJUST, 64'd0, 7'sd63);
		put_word(CMD_ADJUST, 64'd0, -7'sd64);
		put_word(CMD_ADJUST, 64'd0, -7'sd64);
		// Walk the step-size boundaries: 60 s, 300 s and 1200 s.
		put_word(CMD_ADJUST, 64'd0, 7'sd11);
		put_word(CMD_ADJUST, 64'd0, 7'sd16);
		put_word(CMD_ADJUST, 64'd0, 7'sd30);
		put_word(CMD_ADJUST, 64'd0, -7'sd64);
		put_word(CMD_ADJUST, 64'd0, 7'sd1);

		// A 10 s run started close to the top of the 64-bit clock.
		base_us = 64'hFFFF_FFFF_FF00_0000;
		put_word(CMD_TOGGLE, base_us, 7'sd0);
		// A reading below the start time counts as no time elapsed.
		put_word(CMD_TICK,   64'd5, 7'sd0);
		put_word(CMD_TICK,   base_us + 64'd4_999_999, 7'sd0);
		// An adjustment while running is ignored.
		put_word(CMD_ADJUST, base_us, 7'sd5);
		put_word(CMD_TOGGLE, base_us + 64'd6_000_000, 7'sd0);
		// Resume early in the clock, so the shifted start time wraps.
		put_word(CMD_TOGGLE, 64'd100, 7'sd0);
		put_word(CMD_TICK,   64'hFFFF_FFFF_FFFF_FFFF, 7'sd0);
		put_word(CMD_TOGGLE, 64'hFFFF_FFFF_FFFF_FFFF, -7'sd1);
		// An adjustment while paused returns to idle with the new duration.
		put_word(CMD_ADJUST, 64'd0, -7'sd1);
		// Run to completion exactly at zero, then tick once more.
		put_word(CMD_TOGGLE, 64'd1000, 7'sd0);
		put_word(CMD_TICK,   64'd5_001_000, 7'sd0);
		put_word(CMD_TICK,   64'd9_000_000, 7'sd0);
		// Restart after completion, then pause at a reading that hits zero.
		put_word(CMD_TOGGLE, 64'd10_000_000, 7'sd0);
		put_word(CMD_TOGGLE, 64'd9_000_000_000, 7'sd0);
		put_word(CMD_TOGGLE, 64'h5A5A_A5A5_0F0F_F0F0, 7'sd0);
		put_word(CMD_RESET,  64'hA5A5_5A5A_F0F0_0F0F, 7'sd42);

		// Random part, in stretches with different amounts of idling.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300) begin
				// Long output hold-off while words keep being offered.
				hold_req = 1'b1;
			end
			if (i == 600) begin
				drain();
				tx_gap_pct = 10;
				rx_gap_pct = 50;
			end
			if (i == 1100) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end
			if (i == 1400) begin
				tx_gap_pct = 35;
				rx_gap_pct = 30;
			end
			if (i == 1650) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end
			random_word();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
